@@ hw/rtl/cdas_pkg.sv @@
// Shared types, constants and calendar helper functions for the date counter.
package cdas_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int YMOD_W  = 9;     // year mod 400 residue

    localparam logic [YMOD_W-1:0]  YEARS_PER_CYCLE = 9'd400;
    localparam logic [YMOD_W-1:0]  YMOD_LAST       = 9'd399;
    localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC       = 4'd12;
    localparam logic [DAY_W-1:0]   DAYS_LONG       = 5'd31;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // Leap test on the year's residue mod 400.
    function automatic logic leap_of(input logic [YMOD_W-1:0] r);
        return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default: len = DAYS_LONG;
        endcase
        return len;
    endfunction

endpackage

@@ hw/rtl/calendar_date_add_subtract.sv @@
// Gregorian date counter: load, add days, subtract days, one month per cycle.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: op; tdata: day, month, year, count
//  m_      | out | m_tvalid/m_tready  | tuser: error; tdata: day, month, year
//
//  Work: one shared subtractor does all the work. Add/subtract steps one
//  month at a time; load reduces the year mod 400 by the same subtractor.
//  An unused op code goes straight to the finish state.
//  Reset: date returns to 1.1.1; no clearing pass.
//  Stalls: a new word is taken while the last result waits; a finished
//  item holds in the finish state until the output register is free.
module calendar_date_add_subtract #(
    parameter int YEAR_LIMIT  = 9999,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [4:0] new_day, [8:5] new_month, [22:9] new_year,
                                   // [38:23] day_count, [39] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [4:0] out_day, [8:5] out_month, [22:9] out_year,
                                   // [23] zero
    output logic        m_tuser    // [0] error
);
    import cdas_pkg::*;

    // Count bits actually used, and the width of the shared accumulator.
    localparam int CNT_BITS = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
    localparam int AW       = (CNT_BITS + 1 > YEAR_W) ? CNT_BITS + 1 : YEAR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_ADD,
        S_SUB,
        S_FIN
    } state_t;

    state_t               state_reg;

    // Committed date and its year-mod-400 residue.
    logic [DAY_W-1:0]     cur_day_reg;
    logic [MONTH_W-1:0]   cur_month_reg;
    logic [YEAR_W-1:0]    cur_year_reg;
    logic [YMOD_W-1:0]    cur_ymod_reg;

    // Working copy during an item.
    logic [AW-1:0]        acc_reg;      // day sum (add), days left (sub), year residue (load)
    logic [DAY_W-1:0]     wday_reg;
    logic [MONTH_W-1:0]   wmonth_reg;
    logic [YEAR_W-1:0]    wyear_reg;
    logic [YMOD_W-1:0]    wymod_reg;
    logic                 commit_reg;
    logic                 err_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [DAY_W-1:0]     out_day_reg;
    logic [MONTH_W-1:0]   out_month_reg;
    logic [YEAR_W-1:0]    out_year_reg;
    logic                 out_err_reg;

    // Input unpack.
    logic [DAY_W-1:0]     in_day;
    logic [MONTH_W-1:0]   in_month;
    logic [YEAR_W-1:0]    in_year;
    logic [15:0]          in_count;
    logic [AW-1:0]        in_count_ext;
    op_t                  in_op;

    assign in_day       = s_tdata[4:0];
    assign in_month     = s_tdata[8:5];
    assign in_year      = s_tdata[22:9];
    assign in_count     = s_tdata[38:23];
    assign in_count_ext = AW'(in_count[CNT_BITS-1:0]);
    assign in_op        = op_t'(s_tuser);

    // Shared subtractor.
    logic                 cur_leap;
    logic [DAY_W-1:0]     cur_mlen;
    logic [AW-1:0]        sub_a;
    logic [AW-1:0]        sub_b;
    logic [AW:0]          sub_diff;
    logic                 sub_borrow;
    logic [AW-1:0]        sub_res;
    logic                 sub_zero;

    assign cur_leap = leap_of(wymod_reg);
    assign cur_mlen = month_len(wmonth_reg, cur_leap);

    always_comb
    begin
        sub_a = acc_reg;
        case (state_reg)
            S_MOD:   sub_b = AW'(YEARS_PER_CYCLE);
            S_ADD:   sub_b = AW'(cur_mlen);
            S_SUB:   sub_b = AW'(wday_reg);
            default: sub_b = '0;
        endcase
    end

    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[AW];
    assign sub_res    = sub_diff[AW-1:0];
    assign sub_zero   = (sub_res == '0);

    // Load validity, evaluated once the residue is reduced below 400.
    logic                 load_leap;
    logic                 load_ok;
    logic [DAY_W-1:0]     sub_neg_day;
    logic                 out_free;

    assign load_leap = leap_of(acc_reg[YMOD_W-1:0]);
    assign load_ok   = (wmonth_reg >= MONTH_JAN) && (wmonth_reg <= MONTH_DEC)
                    && (wyear_reg != '0) && (wyear_reg <= YEAR_W'(YEAR_LIMIT))
                    && (wday_reg != '0)
                    && (wday_reg <= month_len(wmonth_reg, load_leap));
    // day - left, when left < day: low bits of the negated difference
    assign sub_neg_day = DAY_W'(~sub_res + AW'(1));
    assign out_free    = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_year_reg, out_month_reg, out_day_reg};
    assign m_tuser  = out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_day_reg   <= DAY_W'(1);
            cur_month_reg <= MONTH_JAN;
            cur_year_reg  <= YEAR_W'(1);
            cur_ymod_reg  <= YMOD_W'(1);
            acc_reg       <= '0;
            wday_reg      <= '0;
            wmonth_reg    <= '0;
            wyear_reg     <= '0;
            wymod_reg     <= '0;
            commit_reg    <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_day_reg   <= '0;
            out_month_reg <= '0;
            out_year_reg  <= '0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            // a finishing item reloads the output register itself
            if (out_valid_reg && m_tready && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        commit_reg <= 1'b0;
                        err_reg    <= 1'b0;
                        wymod_reg  <= cur_ymod_reg;
                        wday_reg   <= (in_op == OP_LOAD) ? in_day : cur_day_reg;
                        wmonth_reg <= (in_op == OP_LOAD) ? in_month : cur_month_reg;
                        wyear_reg  <= (in_op == OP_LOAD) ? in_year : cur_year_reg;
                        case (in_op)
                            OP_LOAD:
                            begin
                                acc_reg    <= AW'(in_year);
                                state_reg  <= S_MOD;
                            end
                            OP_ADD:
                            begin
                                acc_reg   <= AW'(cur_day_reg) + in_count_ext;
                                state_reg <= S_ADD;
                            end
                            OP_SUB:
                            begin
                                acc_reg   <= in_count_ext;
                                state_reg <= S_SUB;
                            end
                            default:
                            begin
                                acc_reg   <= '0;
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end

                S_MOD:
                begin
                    if (!sub_borrow)
                    begin
                        acc_reg <= sub_res;
                    end
                    else
                    begin
                        wymod_reg  <= acc_reg[YMOD_W-1:0];
                        commit_reg <= load_ok;
                        err_reg    <= !load_ok;
                        state_reg  <= S_FIN;
                    end
                end

                S_ADD:
                begin
                    if (sub_borrow || sub_zero)
                    begin
                        // day sum fits in this month
                        wday_reg   <= acc_reg[DAY_W-1:0];
                        commit_reg <= 1'b1;
                        state_reg  <= S_FIN;
                    end
                    else
                    begin
                        acc_reg <= sub_res;
                        if (wmonth_reg == MONTH_DEC)
                        begin
                            if (wyear_reg == YEAR_W'(YEAR_LIMIT))
                            begin
                                err_reg   <= 1'b1;
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                wmonth_reg <= MONTH_JAN;
                                wyear_reg  <= wyear_reg + YEAR_W'(1);
                                wymod_reg  <= (wymod_reg == YMOD_LAST) ? '0
                                                                      : wymod_reg + YMOD_W'(1);
                            end
                        end
                        else
                        begin
                            wmonth_reg <= wmonth_reg + MONTH_W'(1);
                        end
                    end
                end

                S_SUB:
                begin
                    if (sub_borrow)
                    begin
                        // fewer days left than the current day: stop here
                        wday_reg   <= sub_neg_day;
                        commit_reg <= 1'b1;
                        state_reg  <= S_FIN;
                    end
                    else
                    begin
                        acc_reg <= sub_res;
                        if (wmonth_reg <= MONTH_JAN)
                        begin
                            if (wyear_reg <= YEAR_W'(1))
                            begin
                                err_reg   <= 1'b1;
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                wmonth_reg <= MONTH_DEC;
                                wyear_reg  <= wyear_reg - YEAR_W'(1);
                                wymod_reg  <= (wymod_reg == '0) ? YMOD_LAST
                                                                : wymod_reg - YMOD_W'(1);
                                wday_reg   <= DAYS_LONG;
                            end
                        end
                        else
                        begin
                            wmonth_reg <= wmonth_reg - MONTH_W'(1);
                            wday_reg   <= month_len(wmonth_reg - MONTH_W'(1), cur_leap);
                        end
                    end
                end

                S_FIN:
                begin
                    if (out_free)
                    begin
                        if (commit_reg)
                        begin
                            cur_day_reg   <= wday_reg;
                            cur_month_reg <= wmonth_reg;
                            cur_year_reg  <= wyear_reg;
                            cur_ymod_reg  <= wymod_reg;
                            out_day_reg   <= wday_reg;
                            out_month_reg <= wmonth_reg;
                            out_year_reg  <= wyear_reg;
                        end
                        else
                        begin
                            out_day_reg   <= cur_day_reg;
                            out_month_reg <= cur_month_reg;
                            out_year_reg  <= cur_year_reg;
                        end
                        out_err_reg   <= err_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A pending result always shows the committed date.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4:0] == cur_day_reg) && (m_tdata[8:5] == cur_month_reg)
                     && (m_tdata[22:9] == cur_year_reg))
        else $error("pending result differs from committed date");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_month_reg >= MONTH_JAN) && (cur_month_reg <= MONTH_DEC) && (cur_day_reg != '0)
        && (cur_day_reg <= month_len(cur_month_reg, leap_of(cur_ymod_reg))))
        else $error("committed date out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_year_reg != '0) && (cur_year_reg <= YEAR_W'(YEAR_LIMIT))
        && (cur_ymod_reg < YEARS_PER_CYCLE))
        else $error("committed year out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD || state_reg == S_SUB) |-> (wymod_reg < YEARS_PER_CYCLE))
        else $error("year residue out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> m_tvalid && (state_reg == S_IDLE))
        else $error("finished item not delivered");

endmodule

@@ verif/tb_calendar_date_add_subtract.sv @@
// Testbench for the Gregorian date counter: directed, back-pressure and random tests.
module tb_calendar_date_add_subtract;

    timeunit 1ns;
    timeprecision 1ps;

    import cdas_pkg::*;

    localparam int YEAR_MAX    = 9999;
    localparam int COUNT_BITS  = 16;
    localparam int RANDOM_WORDS = 220;
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 50;  // quiet time after the last result

    // One result word as the predictor sees it.
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               err;
    } date_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // [4:0] new_day, [8:5] new_month, [22:9] new_year,
                                 // [38:23] day_count, [39] zero
    logic [1:0]  s_tuser = '0;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [4:0] out_day, [8:5] out_month, [22:9] out_year, [23] zero
    logic        m_tuser;        // [0] error

    // Predictor copy of the date register.
    int unsigned cal_day   = 1;
    int unsigned cal_month = 1;
    int unsigned cal_year  = 1;

    date_word_t pending_dates[$];   // expected result words, oldest first
    int         fail_count = 0;
    bit         tx_idle_on = 1'b0;
    bit         rx_idle_on = 1'b0;
    int         rx_hold = 0;        // receiver hold-off request, in cycles

    calendar_date_add_subtract #(
        .YEAR_LIMIT (YEAR_MAX),
        .COUNT_WIDTH(COUNT_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop, well above the slowest legal run.
    initial
    begin
        #30_000_000;
        $display("tb_calendar_date_add_subtract NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    // Full Gregorian rule: every 4th year, except centuries not divisible by 400.
    function automatic bit is_leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(int unsigned m, int unsigned y);
        if (m == MONTH_FEB)
            return is_leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic bit date_is_valid(int unsigned d, int unsigned m, int unsigned y);
        if (m < MONTH_JAN || m > MONTH_DEC)
            return 1'b0;
        if (y < 1 || y > YEAR_MAX)
            return 1'b0;
        return (d >= 1) && (d <= days_in_month(m, y));
    endfunction

    // Applies one word to the predicted date and returns the expected result.
    // Rejected words (bad load, year carry or borrow out of range) leave the date alone.
    function automatic date_word_t next_calendar_date(op_t op, logic [4:0] nd,
                                                      logic [3:0] nm, logic [13:0] ny,
                                                      logic [15:0] cnt);
        date_word_t  r;
        longint      d;
        int unsigned m;
        int unsigned y;
        bit          err;
        err = 1'b0;
        m = cal_month;
        y = cal_year;
        case (op)
            OP_LOAD:
            begin
                if (date_is_valid(nd, nm, ny))
                begin
                    cal_day = nd;
                    cal_month = nm;
                    cal_year = ny;
                end
                else
                    err = 1'b1;
            end
            OP_ADD:
            begin
                d = longint'(cal_day) + longint'(cnt);
                while (!err && d > days_in_month(m, y))
                begin
                    d -= days_in_month(m, y);
                    m++;
                    if (m > MONTH_DEC)
                    begin
                        m = MONTH_JAN;
                        y++;
                        if (y > YEAR_MAX)
                            err = 1'b1;
                    end
                end
                if (!err)
                begin
                    cal_day = 32'(d);
                    cal_month = m;
                    cal_year = y;
                end
            end
            OP_SUB:
            begin
                d = longint'(cal_day) - longint'(cnt);
                while (!err && d < 1)
                begin
                    if (m <= MONTH_JAN && y <= 1)
                        err = 1'b1;     // borrow below year 1
                    else
                    begin
                        if (m <= MONTH_JAN)
                        begin
                            m = MONTH_DEC;
                            y--;
                        end
                        else
                            m--;
                        d += days_in_month(m, y);
                    end
                end
                if (!err)
                begin
                    cal_day = 32'(d);
                    cal_month = m;
                    cal_year = y;
                end
            end
            default: ;  // unused code: date unchanged, no error
        endcase
        r.day = cal_day[DAY_W-1:0];
        r.month = cal_month[MONTH_W-1:0];
        r.year = cal_year[YEAR_W-1:0];
        r.err = err;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver side
    // ------------------------------------------------------------------

    // Offers one word and returns at the edge where it is taken; the expected
    // result is queued at that edge. tvalid stays high for a following word.
    task automatic send_word(input op_t op, input logic [4:0] nd, input logic [3:0] nm,
                             input logic [13:0] ny, input logic [15:0] cnt);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, cnt, ny, nm, nd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_dates.push_back(next_calendar_date(op, nd, nm, ny, cnt));
    endtask

    task automatic load_date(input int d, input int m, input int y);
        send_word(OP_LOAD, d[4:0], m[3:0], y[13:0], 16'($urandom));
    endtask

    // Load fields are don't-care for add/sub, so they carry random bits.
    task automatic step_days(input op_t op, input int cnt);
        send_word(op, 5'($urandom), 4'($urandom), 14'($urandom), cnt[15:0]);
    endtask

    // Sender goes quiet until every expected word has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_dates.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    // m_tready: long hold-off on request, otherwise random stall bursts while idling is on.
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else if (burst > 0)
            begin
                m_tready <= 1'b0;
                burst--;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                burst = $urandom_range(0, 5);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        date_word_t exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_dates.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got %0d.%0d.%0d err=%0d",
                         $time, m_tdata[4:0], m_tdata[8:5], m_tdata[22:9], m_tuser);
                fail_count++;
            end
            else
            begin
                exp_w = pending_dates.pop_front();
                check_field("day", exp_w.day, m_tdata[4:0]);
                check_field("month", exp_w.month, m_tdata[8:5]);
                check_field("year", exp_w.year, m_tdata[22:9]);
                check_field("error", exp_w.err, m_tuser);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset date is 1.1.1; no-op codes and zero counts keep it; stepping back underflows.
    task automatic test_after_reset();
        send_word(OP_NONE, '1, '1, '1, '1);
        step_days(OP_ADD, 0);
        step_days(OP_SUB, 1);
    endtask

    // Range checks on load, including month length and the leap-year rule.
    task automatic test_load_validation();
        load_date(31, 12, YEAR_MAX);
        load_date(0, 1, 5);         // day zero
        load_date(1, 0, 5);         // month zero
        load_date(1, 13, 5);        // month past December
        load_date(31, 15, 16383);   // every field all ones
        load_date(1, 1, 0);         // year zero
        load_date(1, 1, YEAR_MAX + 1);
        load_date(29, 2, 1900);     // century, not leap
        load_date(29, 2, 2000);     // 400-year, leap
        load_date(31, 4, 2001);     // 30-day month
        load_date(29, 2, 2024);
    endtask

    // Carry into the last year, then past the year limit.
    task automatic test_add_carry();
        load_date(31, 12, YEAR_MAX - 1);
        step_days(OP_ADD, 1);
        step_days(OP_ADD, 365);     // would reach year 10000
        step_days(OP_ADD, 364);
        step_days(OP_ADD, 65535);
    endtask

    // Borrow across months and years, longest count, leap February.
    task automatic test_sub_borrow();
        step_days(OP_SUB, 0);
        step_days(OP_SUB, 65535);
        load_date(1, 3, 2000);
        step_days(OP_SUB, 1);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the block backs up and drops s_tready.
    task automatic test_output_backpressure();
        int i;
        tx_idle_on = 1'b0;
        rx_hold = HOLD_CYCLES;
        for (i = 0; i < 8; i++)
            step_days(i[0] ? OP_SUB : OP_ADD, $urandom_range(0, 100));
        wait_drained();
    endtask

    // Sender stops until all results are back, then carries on.
    task automatic test_pause_until_drained();
        int i;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (i = 0; i < 4; i++)
            step_days(OP_ADD, $urandom_range(0, 800));
        wait_drained();
        for (i = 0; i < 4; i++)
            step_days(OP_SUB, $urandom_range(0, 800));
    endtask

    function automatic int random_year();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return $urandom_range(1, 12);               // near the lower bound
        if (sel < 60)
            return $urandom_range(YEAR_MAX - 14, YEAR_MAX);
        return $urandom_range(1, YEAR_MAX);
    endfunction

    // Mostly short steps, some multi-year and a few near the full count range.
    function automatic int random_count();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 65)
            return $urandom_range(0, 60);
        if (sel < 88)
            return $urandom_range(0, 1500);
        if (sel < 97)
            return $urandom_range(0, 40000);
        return $urandom_range(0, 65535);
    endfunction

    // Random mix: valid loads near both year bounds, adds and subs, some junk
    // loads and unused codes. Idling is switched off for a middle stretch and
    // for the tail of the run.
    task automatic test_random_mix();
        int n;
        int sel;
        int m;
        int y;
        n = 0;
        while (n < RANDOM_WORDS)
        begin
            tx_idle_on = !((n >= 70 && n < 100) || n >= RANDOM_WORDS - 40);
            rx_idle_on = tx_idle_on;
            sel = $urandom_range(0, 99);
            if (sel < 5)
                send_word(OP_NONE, 5'($urandom), 4'($urandom), 14'($urandom),
                          16'($urandom));
            else
            begin
                if (sel < 15)
                    send_word(OP_LOAD, 5'($urandom), 4'($urandom), 14'($urandom),
                              16'($urandom));
                else if (sel < 38)
                begin
                    m = $urandom_range(1, 12);
                    y = random_year();
                    load_date($urandom_range(1, days_in_month(m, y)), m, y);
                end
                else if (sel < 69)
                    step_days(OP_ADD, random_count());
                else
                    step_days(OP_SUB, random_count());
                n++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_after_reset();
        test_load_validation();
        test_add_carry();
        test_sub_borrow();
        test_output_backpressure();
        test_pause_until_drained();
        test_random_mix();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_calendar_date_add_subtract OK");
        else
            $display("tb_calendar_date_add_subtract NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/cdas_pkg.sv
hw/rtl/calendar_date_add_subtract.sv
verif/tb_calendar_date_add_subtract.sv
